>>> src/key_value_set_table_top_assert.svh
// Assertion macros shared by the key/value set table modules.
`ifndef KEY_VALUE_SET_TABLE_TOP_ASSERT_SVH
`define KEY_VALUE_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KVS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kvs_pkg.sv
package kvs_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int OPC_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OPC_W-1:0] OPC_ADD      = 2'd0;
    localparam logic [OPC_W-1:0] OPC_REMOVE   = 2'd1;
    localparam logic [OPC_W-1:0] OPC_CONTAINS = 2'd2;

    localparam logic signed [KEY_W-1:0] SENTINEL_KEY = 32'sh8000_0000;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_REMOVE,
        KIND_CONTAINS,
        KIND_NONE
    } kvs_kind_t;

    typedef struct packed {
        kvs_kind_t                kind;
        logic signed [KEY_W-1:0]  key;
        logic        [VAL_W-1:0]  value;
    } kvs_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RESOLVE,
        ST_FETCH,
        ST_EMIT
    } kvs_state_t;

    typedef struct packed {
        logic pop;
        logic do_insert;
        logic do_remove;
        logic emit;
    } kvs_ctrl_t;

    // One-hot (or zero) vector to entry index.
    function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [CAPACITY-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (vec[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> src/kvs_ram.sv
module kvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/kvs_front.sv
module kvs_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kvs_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                q_full_i,
    output logic                                push_o,
    output kvs_pkg::kvs_cmd_t                   cmd_o
);

    logic [kvs_pkg::OPC_W-1:0]        opcode;
    logic signed [kvs_pkg::KEY_W-1:0] key;
    logic [kvs_pkg::VAL_W-1:0]        value_in;
    logic                             is_sentinel;

    assign opcode   = s_tdata[1:0];
    assign key      = s_tdata[33:2];
    assign value_in = s_tdata[65:34];

    assign is_sentinel = (key == kvs_pkg::SENTINEL_KEY);

    // Sentinel key and the unused opcode both reduce to a no-op.
    always_comb begin
        cmd_o.key   = key;
        cmd_o.value = value_in;
        case (opcode)
            kvs_pkg::OPC_ADD:      cmd_o.kind = is_sentinel ? kvs_pkg::KIND_NONE
                                                            : kvs_pkg::KIND_ADD;
            kvs_pkg::OPC_REMOVE:   cmd_o.kind = is_sentinel ? kvs_pkg::KIND_NONE
                                                            : kvs_pkg::KIND_REMOVE;
            kvs_pkg::OPC_CONTAINS: cmd_o.kind = is_sentinel ? kvs_pkg::KIND_NONE
                                                            : kvs_pkg::KIND_CONTAINS;
            default:               cmd_o.kind = kvs_pkg::KIND_NONE;
        endcase
    end

    assign s_tready = !q_full_i;
    assign push_o   = s_tvalid && !q_full_i;

endmodule

>>> src/kvs_queue.sv
module kvs_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_i,
    input  kvs_pkg::kvs_cmd_t push_cmd_i,
    output logic              full_o,
    input  logic              pop_i,
    output kvs_pkg::kvs_cmd_t head_cmd_o,
    output logic              head_valid_o
);

    kvs_pkg::kvs_cmd_t           mem_reg [kvs_pkg::QUEUE_DEPTH];
    logic [kvs_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [kvs_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [kvs_pkg::QCNT_W-1:0]  count_reg;
    logic [kvs_pkg::QCNT_W-1:0]  count_next;

    assign full_o       = (count_reg == kvs_pkg::QCNT_W'(kvs_pkg::QUEUE_DEPTH));
    assign head_valid_o = (count_reg != '0);
    assign head_cmd_o   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_i && !pop_i) begin
            count_next = count_reg + 1'b1;
        end else if (pop_i && !push_i) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_i) begin
                wr_ptr_reg <= (wr_ptr_reg == kvs_pkg::QPTR_W'(kvs_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_i) begin
                rd_ptr_reg <= (rd_ptr_reg == kvs_pkg::QPTR_W'(kvs_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= push_cmd_i;
        end
    end

`include "key_value_set_table_top_assert.svh"

    `KVS_ASSERT_NOW(a_q_no_overflow, aclk, aresetn, push_i && !pop_i, !full_o, "queue overflow")
    `KVS_ASSERT_NOW(a_q_no_underflow, aclk, aresetn, pop_i, head_valid_o, "queue underflow")

endmodule

>>> src/kvs_back.sv
module kvs_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  kvs_pkg::kvs_cmd_t         cmd_i,
    input  logic                      cmd_valid_i,
    output logic                      cmd_pop_o,
    output logic                      m_tvalid_o,
    input  logic                      m_tready_i,
    output logic                      success_o,
    output logic [kvs_pkg::VAL_W-1:0] value_out_o,
    output logic                      table_full_o
);

    kvs_pkg::kvs_state_t  state_reg, state_next;
    kvs_pkg::kvs_ctrl_t   ctrl;
    kvs_pkg::kvs_cmd_t    cmd_reg;

    logic signed [kvs_pkg::KEY_W-1:0] entry_key_reg [kvs_pkg::CAPACITY];
    logic [kvs_pkg::CAPACITY-1:0]     entry_valid_reg, entry_valid_next;

    logic [kvs_pkg::CAPACITY-1:0] match_vec;
    logic [kvs_pkg::CAPACITY-1:0] match_reg;
    logic [kvs_pkg::CAPACITY-1:0] lowfree_reg;
    logic                         full_reg;

    logic                         hit;
    logic [kvs_pkg::IDX_W-1:0]    hit_idx;
    logic [kvs_pkg::IDX_W-1:0]    free_idx;
    logic                         out_free;

    logic                         res_success_reg;
    logic [kvs_pkg::VAL_W-1:0]    res_value_reg;
    logic                         res_full_reg;

    logic                         out_valid_reg;
    logic                         out_success_reg;
    logic [kvs_pkg::VAL_W-1:0]    out_value_reg;
    logic                         out_full_reg;

    logic [kvs_pkg::VAL_W-1:0]    ram_rdata;

    // key cells: each compares its own stored key
    always_comb begin
        for (int i = 0; i < kvs_pkg::CAPACITY; i++) begin
            match_vec[i] = entry_valid_reg[i] && (entry_key_reg[i] == cmd_reg.key);
        end
    end

    assign hit      = |match_reg;
    assign hit_idx  = kvs_pkg::onehot_to_idx(match_reg);
    assign free_idx = kvs_pkg::onehot_to_idx(lowfree_reg);
    assign out_free = !out_valid_reg || m_tready_i;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kvs_pkg::ST_IDLE: begin
                if (cmd_valid_i) state_next = kvs_pkg::ST_MATCH;
            end
            kvs_pkg::ST_MATCH: begin
                state_next = kvs_pkg::ST_RESOLVE;
            end
            kvs_pkg::ST_RESOLVE: begin
                state_next = (cmd_reg.kind == kvs_pkg::KIND_REMOVE && hit)
                             ? kvs_pkg::ST_FETCH : kvs_pkg::ST_EMIT;
            end
            kvs_pkg::ST_FETCH: begin
                state_next = kvs_pkg::ST_EMIT;
            end
            kvs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = cmd_valid_i ? kvs_pkg::ST_MATCH : kvs_pkg::ST_IDLE;
                end
            end
            default: state_next = kvs_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ctrl = '0;
        case (state_reg)
            kvs_pkg::ST_IDLE: begin
                ctrl.pop = cmd_valid_i;
            end
            kvs_pkg::ST_RESOLVE: begin
                ctrl.do_insert = (cmd_reg.kind == kvs_pkg::KIND_ADD) && !hit && !full_reg;
                ctrl.do_remove = (cmd_reg.kind == kvs_pkg::KIND_REMOVE) && hit;
            end
            kvs_pkg::ST_EMIT: begin
                ctrl.emit = out_free;
                ctrl.pop  = out_free && cmd_valid_i;
            end
            default: ctrl = '0;
        endcase
    end

    assign cmd_pop_o = ctrl.pop;

    always_comb begin
        entry_valid_next = entry_valid_reg;
        if (ctrl.do_insert) begin
            entry_valid_next = entry_valid_reg | lowfree_reg;
        end else if (ctrl.do_remove) begin
            entry_valid_next = entry_valid_reg & ~match_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= kvs_pkg::ST_IDLE;
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_valid_reg <= entry_valid_next;
            if (ctrl.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready_i) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            cmd_reg <= cmd_i;
        end
        if (state_reg == kvs_pkg::ST_MATCH) begin
            match_reg   <= match_vec;
            // lowest clear bit of the valid vector
            lowfree_reg <= ~entry_valid_reg & (entry_valid_reg + 1'b1);
            full_reg    <= &entry_valid_reg;
        end
        if (ctrl.do_insert) begin
            entry_key_reg[free_idx] <= cmd_reg.key;
        end
        if (state_reg == kvs_pkg::ST_RESOLVE) begin
            res_success_reg <= ctrl.do_insert || ctrl.do_remove
                               || (cmd_reg.kind == kvs_pkg::KIND_CONTAINS && hit);
            res_full_reg    <= (cmd_reg.kind == kvs_pkg::KIND_ADD) && !hit && full_reg;
            res_value_reg   <= '0;
        end
        if (state_reg == kvs_pkg::ST_FETCH) begin
            res_value_reg <= ram_rdata;
        end
        if (ctrl.emit) begin
            out_success_reg <= res_success_reg;
            out_value_reg   <= res_value_reg;
            out_full_reg    <= res_full_reg;
        end
    end

    kvs_ram #(
        .WIDTH (kvs_pkg::VAL_W),
        .DEPTH (kvs_pkg::CAPACITY)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ctrl.do_insert),
        .waddr (free_idx),
        .wdata (cmd_reg.value),
        .re    (ctrl.do_remove),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    assign m_tvalid_o   = out_valid_reg;
    assign success_o    = out_success_reg;
    assign value_out_o  = out_value_reg;
    assign table_full_o = out_full_reg;

`include "key_value_set_table_top_assert.svh"

    `KVS_ASSERT_NOW(a_key_unique, aclk, aresetn, state_reg == kvs_pkg::ST_RESOLVE, $onehot0(match_reg), "key held in more than one entry")
    `KVS_ASSERT_NOW(a_free_slot_onehot, aclk, aresetn, state_reg == kvs_pkg::ST_RESOLVE && !full_reg, $onehot(lowfree_reg), "free slot not one-hot")
    `KVS_ASSERT_NEXT(a_insert_sets_valid, aclk, aresetn, ctrl.do_insert, $countones(entry_valid_reg) == $countones($past(entry_valid_reg)) + 1, "insert did not add an entry")
    `KVS_ASSERT_NEXT(a_emit_presents, aclk, aresetn, ctrl.emit, m_tvalid_o, "result not presented")

endmodule

>>> src/key_value_set_table_top.sv
// An accepted item passes through the queue, then the back-end states match, resolve and emit,
//   with a fetch state for the registered read of the value RAM on a remove that finds its key.
// The back-end sequencer takes one item at a time and holds in emit while a result is held.
// A 2-item queue decouples input acceptance from execution; a held result stalls input once it fills.
// Reset (aresetn low, synchronous): all entries invalid, queue empty, no result pending.
//   No clearing pass is run; the block accepts items as soon as reset is released.
module key_value_set_table_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kvs_pkg::IN_TDATA_W-1:0]      s_tdata,  // opcode[1:0], key[33:2],
                                                          // value_in[65:34], zero pad
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kvs_pkg::OUT_TDATA_W-1:0]     m_tdata   // success[0], value_out[32:1],
                                                          // table_full[33], zero pad
);

    kvs_pkg::kvs_cmd_t          front_cmd;
    kvs_pkg::kvs_cmd_t          head_cmd;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       head_valid;
    logic                       success;
    logic [kvs_pkg::VAL_W-1:0]  value_out;
    logic                       table_full;

    // Front end: handshake and opcode/sentinel classification
    kvs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full_i (q_full),
        .push_o   (push),
        .cmd_o    (front_cmd)
    );

    // Short queue between front and back
    kvs_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_i       (push),
        .push_cmd_i   (front_cmd),
        .full_o       (q_full),
        .pop_i        (pop),
        .head_cmd_o   (head_cmd),
        .head_valid_o (head_valid)
    );

    // Back end: parallel key compare, table update, value RAM and output register
    kvs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (head_cmd),
        .cmd_valid_i  (head_valid),
        .cmd_pop_o    (pop),
        .m_tvalid_o   (m_tvalid),
        .m_tready_i   (m_tready),
        .success_o    (success),
        .value_out_o  (value_out),
        .table_full_o (table_full)
    );

    // Pack result fields, lowest field first, zero-padded to whole bytes
    assign m_tdata = {6'b0, table_full, value_out, success};

endmodule
